[rtl/core/dcp_pkg.sv]
`timescale 1ns / 1ps

package dcp_pkg;

  // Field and datapath widths.
  localparam int SampleW = 16;
  localparam int WinW    = 15;
  localparam int QuotW   = 8;
  localparam int NumW    = WinW + QuotW;
  localparam int ColorW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  // Number of divider cells, one per quotient bit.
  localparam int DivCells = QuotW;

  // Color constants of the palettes.
  localparam logic [ColorW-1:0] ColorMax = 8'hFF;
  localparam logic [ColorW:0]   HalfSpan = 9'd128;
  localparam logic [15:0]       GreenLow = 16'd200;
  localparam logic [15:0]       GreenTop = 16'd25600;  // 200 * 128
  localparam logic [15:0]       GreenDec = 16'd96;     // 200 - 104
  localparam logic [15:0]       Full     = 16'd255;

  // Reset values of the configuration registers.
  localparam logic [WinW-1:0]    WindowLowRst   = 15'd0;
  localparam logic [WinW-1:0]    WindowHighRst  = 15'd2000;
  localparam logic [SampleW-1:0] InvalidCodeRst = 16'd0;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LOW   = 2'd0,
    REG_WINDOW_HIGH  = 2'd1,
    REG_INVALID_CODE = 2'd2,
    REG_PALETTE_MODE = 2'd3
  } dcp_reg_t;

  // Palette selection.
  typedef enum logic {
    PAL_GRAY     = 1'b0,
    PAL_BLUE_RED = 1'b1
  } dcp_palette_t;

  // Per-pixel flags that ride along the pipeline.
  typedef struct packed {
    logic blank;
    logic empty;
  } dcp_flags_t;

  // Divider token handed from cell to cell.
  // rem holds the partial remainder; bits holds the remaining dividend bits
  // at the top and the quotient bits produced so far at the bottom.
  typedef struct packed {
    logic [WinW-1:0]  rem;
    logic [QuotW-1:0] bits;
    logic [WinW-1:0]  span;
    dcp_flags_t       flags;
  } dcp_div_t;

endpackage

[rtl/core/dcp_prep.sv]
`timescale 1ns / 1ps

module dcp_prep
  import dcp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SampleW-1:0]  depth_sample,
  input  logic [WinW-1:0]     window_low,
  input  logic [WinW-1:0]     window_high,
  input  logic [SampleW-1:0]  invalid_code,
  output logic                out_valid,
  input  logic                out_ready,
  output dcp_div_t            out_data
);

  logic signed [SampleW-1:0] sample_s;
  logic signed [SampleW-1:0] low_s;
  logic signed [SampleW-1:0] high_s;
  logic [WinW-1:0]           offset;
  logic [NumW-1:0]           numer;
  dcp_div_t                  data_next;

  // Window test and the scaled numerator offset * 255.
  always_comb begin
    sample_s = depth_sample;
    low_s    = {1'b0, window_low};
    high_s   = {1'b0, window_high};
    offset   = depth_sample[WinW-1:0] - window_low;
    numer    = {offset, {QuotW{1'b0}}} - NumW'(offset);

    data_next.flags.blank = (depth_sample == invalid_code) || (sample_s > high_s) ||
                            (sample_s < low_s);
    data_next.flags.empty = (window_high == window_low);
    data_next.span        = window_high - window_low;
    data_next.rem         = numer[NumW-1:QuotW];
    data_next.bits        = numer[QuotW-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/core/dcp_div_cell.sv]
`timescale 1ns / 1ps

module dcp_div_cell
  import dcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dcp_div_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dcp_div_t out_data
);

  logic [WinW:0] trial;
  logic [WinW:0] divisor;
  logic          take;
  dcp_div_t      data_next;

  // One restoring division step: bring down the next dividend bit and
  // subtract the span when it fits.
  always_comb begin
    trial   = {in_data.rem, in_data.bits[QuotW-1]};
    divisor = {1'b0, in_data.span};
    take    = (trial >= divisor);

    data_next       = in_data;
    data_next.bits  = {in_data.bits[QuotW-2:0], take};
    if (take) begin
      data_next.rem = WinW'(trial - divisor);
    end else begin
      data_next.rem = trial[WinW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/core/dcp_render.sv]
`timescale 1ns / 1ps

module dcp_render
  import dcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcp_div_t          in_data,
  input  logic              palette_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ColorW-1:0] blue,
  output logic [ColorW-1:0] green,
  output logic [ColorW-1:0] red,
  output logic              blanked,
  output logic              empty_window
);

  logic [WinW:0]       twice_rem;
  logic [WinW:0]       divisor;
  logic                round_up;
  logic [QuotW:0]      rounded;
  logic [ColorW-1:0]   level;
  logic [ColorW:0]     t_ext;
  logic [ColorW:0]     t_rest;
  logic [15:0]         prod_blue;
  logic [15:0]         prod_green;
  logic [15:0]         prod_red;
  logic [ColorW-1:0]   blue_next;
  logic [ColorW-1:0]   green_next;
  logic [ColorW-1:0]   red_next;

  // Round to nearest, ties to even, then map the level through the palette.
  always_comb begin
    twice_rem = {in_data.rem, 1'b0};
    divisor   = {1'b0, in_data.span};
    round_up  = (twice_rem > divisor) || ((twice_rem == divisor) && in_data.bits[0]);
    rounded   = {1'b0, in_data.bits} + (QuotW+1)'(round_up);
    if (in_data.flags.empty) begin
      level = '0;
    end else if (rounded[QuotW]) begin
      level = ColorMax;
    end else begin
      level = rounded[QuotW-1:0];
    end

    t_ext      = {2'b00, level[ColorW-2:0]};
    t_rest     = HalfSpan - t_ext;
    prod_blue  = Full * 16'(t_ext);
    prod_red   = Full * 16'(t_rest);
    prod_green = '0;
    blue_next  = '0;
    green_next = '0;
    red_next   = '0;

    if (in_data.flags.blank) begin
      blue_next  = '0;
    end else if (palette_mode == PAL_GRAY) begin
      blue_next  = ColorMax - level;
      green_next = ColorMax - level;
      red_next   = ColorMax - level;
    end else if (!level[ColorW-1]) begin
      // Lower segment: red fixed, green ramps up.
      prod_green = GreenLow * 16'(t_ext);
      green_next = prod_green[14:7];
      red_next   = ColorMax;
    end else begin
      // Upper segment: blue rises, red falls, green blends from 200 to 104.
      prod_green = GreenTop - GreenDec * 16'(t_ext);
      blue_next  = prod_blue[14:7];
      green_next = prod_green[14:7];
      red_next   = prod_red[14:7];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      blue         <= blue_next;
      green        <= green_next;
      red          <= red_next;
      blanked      <= in_data.flags.blank;
      empty_window <= in_data.flags.empty;
    end
  end

endmodule

[rtl/core/depth_to_color_pixel_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     depth_sample
// output    out_valid / out_ready   blue, green, red, blanked, empty_window
// config    cfg_write               cfg_index, cfg_data
//
// One pixel enters per cycle while the output is not stalled; each pixel passes
// through a prepare stage, a chain of 8 divider cells (one quotient bit each) and a
// render stage that rounds and applies the palette.
// Reset is synchronous and clears the stage valid bits and the configuration.
// Each stage stalls only when it holds a pixel its successor cannot take, so
// bubbles close up and input is taken while a finished pixel waits.

module depth_to_color_pixel_core
  import dcp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SampleW-1:0]  depth_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ColorW-1:0]   blue,
  output logic [ColorW-1:0]   green,
  output logic [ColorW-1:0]   red,
  output logic                blanked,
  output logic                empty_window,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  logic [WinW-1:0]    window_low;
  logic [WinW-1:0]    window_high;
  logic [SampleW-1:0] invalid_code;
  logic               palette_mode;

  logic               chain_valid [DivCells+1];
  logic               chain_ready [DivCells+1];
  dcp_div_t           chain_data  [DivCells+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_low   <= WindowLowRst;
      window_high  <= WindowHighRst;
      invalid_code <= InvalidCodeRst;
      palette_mode <= PAL_BLUE_RED;
    end else if (cfg_write) begin
      unique case (dcp_reg_t'(cfg_index))
        REG_WINDOW_LOW:   window_low   <= cfg_data[WinW-1:0];
        REG_WINDOW_HIGH:  window_high  <= cfg_data[WinW-1:0];
        REG_INVALID_CODE: invalid_code <= cfg_data[SampleW-1:0];
        REG_PALETTE_MODE: palette_mode <= cfg_data[0];
        default:          palette_mode <= palette_mode;
      endcase
    end
  end

  // Window test and numerator setup.
  dcp_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .depth_sample (depth_sample),
    .window_low   (window_low),
    .window_high  (window_high),
    .invalid_code (invalid_code),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out_data     (chain_data[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < DivCells; i++) begin : g_cell
    dcp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // Rounding, palette and output register.
  dcp_render u_render (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chain_valid[DivCells]),
    .in_ready     (chain_ready[DivCells]),
    .in_data      (chain_data[DivCells]),
    .palette_mode (palette_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .blanked      (blanked),
    .empty_window (empty_window)
  );

  // A blanked pixel is black.
  a_blank_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && blanked |-> blue == '0 && green == '0 && red == '0)
    else $error("blanked pixel is not black");

  // Gray palette gives equal channels.
  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && palette_mode == PAL_GRAY |-> blue == green && green == red)
    else $error("gray pixel has unequal channels");

  // With equal window bounds a shown pixel sits at the bottom of the gradient.
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_window && !blanked && palette_mode == PAL_BLUE_RED
    |-> red == ColorMax && blue == '0 && green == '0)
    else $error("empty window pixel is not at level zero");

  // Input is refused only when the whole pipeline is full and the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused with room in the pipeline");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dcp_pkg::*;

  localparam int IdleLimit  = 5000;
  localparam int DrainExtra = 12;

  // One rendered pixel as seen on the output channel.
  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic              blanked;
    logic              empty_window;
  } pixel_t;

  // Keeps a copy of the configuration, predicts the pixel for every accepted
  // sample and checks the output pixels in order.
  class pixel_scoreboard;
    logic [WinW-1:0]    win_low;
    logic [WinW-1:0]    win_high;
    logic [SampleW-1:0] inv_code;
    dcp_palette_t       palette;
    pixel_t             expected_pixels[$];
    logic [SampleW-1:0] expected_samples[$];
    int                 mismatches;

    function new();
      win_low    = WindowLowRst;
      win_high   = WindowHighRst;
      inv_code   = InvalidCodeRst;
      palette    = PAL_BLUE_RED;
      mismatches = 0;
    endfunction

    // Registers keep only their low bits.
    function void set_reg(dcp_reg_t idx, logic [CfgW-1:0] data);
      case (idx)
        REG_WINDOW_LOW:   win_low = data[WinW-1:0];
        REG_WINDOW_HIGH:  win_high = data[WinW-1:0];
        REG_INVALID_CODE: inv_code = data[SampleW-1:0];
        REG_PALETTE_MODE: palette = dcp_palette_t'(data[0]);
        default: ;
      endcase
    endfunction

    function pixel_t render_pixel(logic [SampleW-1:0] sample);
      pixel_t px;
      int     v, lo, hi, span, n, q, r, t;
      logic   blank, empty;
      v = int'($signed(sample));
      lo = int'(win_low);
      hi = int'(win_high);
      px = '0;
      blank = (sample == inv_code) || (v > hi) || (v < lo);
      empty = (win_high == win_low);
      q = 0;
      if (!blank) begin
        // Scale into 0..255, rounding to nearest with ties to even.
        if (!empty) begin
          span = hi - lo;
          n = (v - lo) * 255;
          q = n / span;
          r = n % span;
          if ((2 * r > span) || ((2 * r == span) && (q % 2 == 1))) q++;
          if (q > 255) q = 255;
        end
        if (palette == PAL_GRAY) begin
          px.blue  = 8'(255 - q);
          px.green = 8'(255 - q);
          px.red   = 8'(255 - q);
        end else if (q < 128) begin
          px.blue  = 8'd0;
          px.green = 8'((200 * q) / 128);
          px.red   = 8'd255;
        end else begin
          t = q - 128;
          px.blue  = 8'((255 * t) / 128);
          px.green = 8'((200 * (128 - t) + 104 * t) / 128);
          px.red   = 8'((255 * (128 - t)) / 128);
        end
      end
      px.blanked      = blank;
      px.empty_window = empty;
      return px;
    endfunction

    function void note_sample(logic [SampleW-1:0] sample);
      expected_pixels.push_back(render_pixel(sample));
      expected_samples.push_back(sample);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t             want;
      logic [SampleW-1:0] sample;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel output: b=%0d g=%0d r=%0d blank=%0b empty=%0b",
                   got.blue, got.green, got.red, got.blanked, got.empty_window);
      end else begin
        want = expected_pixels.pop_front();
        sample = expected_samples.pop_front();
        if ((got.blue !== want.blue) || (got.green !== want.green) ||
            (got.red !== want.red) || (got.blanked !== want.blanked) ||
            (got.empty_window !== want.empty_window)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch for sample %0d: expected b=%0d g=%0d r=%0d blank=%0b empty=%0b",
                     $signed(sample), want.blue, want.green, want.red, want.blanked,
                     want.empty_window);
            $display("  got b=%0d g=%0d r=%0d blank=%0b empty=%0b",
                     got.blue, got.green, got.red, got.blanked, got.empty_window);
          end
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [SampleW-1:0] depth_sample;
  logic               out_valid;
  logic               out_ready;
  logic [ColorW-1:0]  blue;
  logic [ColorW-1:0]  green;
  logic [ColorW-1:0]  red;
  logic               blanked;
  logic               empty_window;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  pixel_scoreboard sb;
  int              burst_left;
  int              idle_cycles;
  int              rx_left;
  int              rx_mode;
  int              rx_count;

  depth_to_color_pixel_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .depth_sample (depth_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .blanked      (blanked),
    .empty_window (empty_window),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one sample; the sender runs in bursts with random gaps between them.
  task automatic send_sample(logic [SampleW-1:0] sample);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid     <= 1'b1;
    depth_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(sample);
    burst_left--;
  endtask

  // Stop sending and wait until every predicted pixel has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainExtra) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles while the block is idle.
  task automatic apply_setting(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi,
                               logic [CfgW-1:0] inv, logic [CfgW-1:0] mode);
    logic [CfgW-1:0] data [4];
    data[0] = lo;
    data[1] = hi;
    data[2] = inv;
    data[3] = mode;
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= dcp_reg_t'(i);
      cfg_data  <= data[i];
      @(posedge clk);
      sb.set_reg(dcp_reg_t'(i), data[i]);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver back-pressure: switches between patterns of random length.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(10, 60);
    end else begin
      rx_left--;
    end
    rx_count++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_count % 4 == 0);
      default: out_ready <= (rx_left < 3);
    endcase
  end

  // Check every output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel({blue, green, red, blanked, empty_window});
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int              lo, hi, sel, kind;
    logic [CfgW-1:0] inv;
    logic [CfgW-1:0] sample;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    depth_sample <= '0;
    out_ready    <= 1'b0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_WINDOW_LOW;
    cfg_data     <= '0;
    burst_left   = 0;
    idle_cycles  = 0;
    rx_left      = 0;
    rx_mode      = 0;
    rx_count     = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: window 0..2000, invalid 0, blue-red gradient.
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'd2000);
    send_sample(16'd2001);
    send_sample(16'hFFFF);
    send_sample(16'd996);
    send_sample(16'd1004);
    send_sample(16'd200);
    send_sample(16'd600);
    wait_for_results();

    // Full window with inverted gray and the most negative invalid label.
    apply_setting(16'h0000, 16'hFFFF, 16'h8000, 16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h4000);
    send_sample(16'hFFFF);
    wait_for_results();

    // Equal bounds: only the bound itself is in window, with g forced to 0.
    apply_setting(16'd100, 16'd100, 16'h7FFF, 16'h0001);
    send_sample(16'd100);
    send_sample(16'd99);
    send_sample(16'd101);
    wait_for_results();

    // Invalid label inside an equal window of the largest depth.
    apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFE);
    wait_for_results();

    // Inverted window blanks every pixel.
    apply_setting(16'd500, 16'd400, 16'h0000, 16'h0001);
    send_sample(16'd450);
    send_sample(16'd500);
    send_sample(16'd400);
    wait_for_results();

    // Random phases, each with a window shape picked from six kinds and a random palette.
    for (int ph = 0; ph < 10; ph++) begin
      kind = ph % 6;
      case (kind)
        0: begin
          lo = 0;
          hi = 32767;
        end
        1: begin
          lo = $urandom_range(0, 32766);
          hi = $urandom_range(32767, lo + 1);
        end
        2: begin
          lo = $urandom_range(0, 30000);
          hi = lo + $urandom_range(1, 300);
        end
        3: begin
          lo = $urandom_range(0, 32767);
          hi = lo;
        end
        4: begin
          lo = $urandom_range(0, 32760);
          hi = lo + $urandom_range(1, 6);
        end
        default: begin
          hi = $urandom_range(0, 32766);
          lo = $urandom_range(32767, hi + 1);
        end
      endcase
      if ((lo <= hi) && ($urandom_range(0, 1) == 1))
        inv = 16'($urandom_range(hi, lo));
      else
        inv = 16'($urandom);
      apply_setting({1'($urandom), 15'(lo)}, {1'($urandom), 15'(hi)}, inv,
                    16'($urandom));
      for (int k = 0; k < 50; k++) begin
        sel = $urandom_range(0, 9);
        if ((sel <= 5) && (lo <= hi)) begin
          sample = 16'($urandom_range(hi, lo));
        end else if (sel == 6) begin
          case ($urandom_range(0, 3))
            0: sample = 16'(lo);
            1: sample = 16'(hi);
            2: sample = 16'(lo - 1);
            default: sample = 16'(hi + 1);
          endcase
        end else if (sel == 7) begin
          sample = inv;
        end else begin
          sample = 16'($urandom);
        end
        send_sample(sample);
        // Hold the sender once in mid-phase until the pipeline is empty.
        if ((ph == 4) && (k == 25)) wait_for_results();
      end
      wait_for_results();
    end

    // Leftover predictions count as failures.
    sb.mismatches += sb.expected_pixels.size();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
